### rtl/core/bta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants
// Heap geometry, tag flags, status codes, sequencer states and tag helpers.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int HeapBytes = 65536;
  localparam int TagWords  = HeapBytes / 4;
  localparam int AddrW     = $clog2(TagWords);
  localparam int TagW      = 16;
  localparam int AluW      = 17;

  localparam logic [TagW-1:0] FlagFree  = 16'h0001;
  localparam logic [TagW-1:0] FlagStart = 16'h0002;
  localparam logic [TagW-1:0] FlagEnd   = 16'h0004;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_NULL = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SETUP,
    S_A_CHK,
    S_A_WR,
    S_F_HS,
    S_F_FT,
    S_F_RDN,
    S_F_NT,
    S_F_MW0,
    S_F_MW1,
    S_F_RDF,
    S_F_FW,
    S_F_PT,
    S_F_HH,
    S_F_PF,
    S_OUT
  } state_t;

  // payload size in tag words (size bytes / 4)
  function automatic logic [AddrW-1:0] tag_words(input logic [TagW-1:0] t);
    tag_words = {t[TagW-1:3], 1'b0};
  endfunction

  // payload size in bytes
  function automatic logic [TagW-1:0] tag_bytes(input logic [TagW-1:0] t);
    tag_bytes = {t[TagW-1:3], 3'b000};
  endfunction

endpackage
`default_nettype wire

### rtl/core/boundary_tag_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Allocate reads one chunk tag per step of the walk (start chunk included), then writes 2 or
// 4 tags (none when out of space); the first allocate sets up the heap before its walk. Free
// updates the chunk and neighbour tags; a null free or one before setup goes straight to output.
// One request at a time; the single tag memory and the shared adder set the pace.
// Result is held in an output register until taken; a new request is taken once it leaves.
// Synchronous active-low reset clears the sequencer and heap-ready flag; tags are not cleared.
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator: first-fit boundary tag heap allocator
// Sequencer walking header/footer tags in a tag memory with one shared adder.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_op,
  input  wire logic [15:0]            in_request_size,
  input  wire logic [15:0]            in_block_address,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [15:0]                 out_result_address,
  output bta_pkg::status_t            out_status
);
  import bta_pkg::*;

  state_t             state_r, state_nxt;
  logic               ready_r, ready_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         last_r, last_nxt;
  logic               first_r, first_nxt;
  logic               zero_r, zero_nxt;
  logic               end_r, end_nxt;
  logic [15:0]        wk_r, wk_nxt;
  logic [AddrW:0]     sw_r, sw_nxt;
  logic [AddrW-1:0]   cw_r, cw_nxt;
  logic [TagW-1:0]    rem_r, rem_nxt;
  logic [AddrW-1:0]   hw_r, hw_nxt;
  logic [AddrW-1:0]   pw_r, pw_nxt;
  logic [TagW-1:0]    hs_r, hs_nxt;
  logic [TagW-1:0]    ps_r, ps_nxt;
  logic [15:0]        result_r, result_nxt;
  status_t            status_r, status_nxt;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [TagW-1:0]    wdata, rdata;
  alu_op_t            alu_op;
  logic [AluW-1:0]    alu_a, alu_b, alu_y;

  logic               t_free, t_end, t_take, t_fit, end_room, split_room, step_full;
  logic [AddrW-1:0]   t_cw;

  bta_ram #(.Width(TagW), .Depth(TagWords)) u_tags (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bta_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // tag decode and fit checks for the walk
  assign t_free     = rdata[0];
  assign t_end      = rdata[2];
  assign t_cw       = tag_words(rdata);
  assign t_take     = !first_r && t_free;
  assign t_fit      = ({1'b0, t_cw} == sw_r) || ({2'b00, t_cw} >= ({1'b0, sw_r} + 16'd2));
  assign end_room   = ({1'b0, wk_r} + 17'd4 + AluW'(sw_r)) <= AluW'(TagWords);
  assign split_room = ({1'b0, wk_r} + 17'd1 + AluW'(t_cw)) < AluW'(TagWords);
  assign step_full  = alu_y >= AluW'(TagWords);

  // handshake
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_result_address = result_r;
  assign out_status         = status_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op) begin
            if (in_block_address == 16'd0 || !ready_r) begin
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_F_HS;
            end
          end else if (!ready_r) begin
            state_nxt = S_SETUP;
          end else if (in_request_size == 16'd0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_A_CHK;
          end
        end
      end
      S_SETUP: begin
        if (cnt_r == 2'd3) begin
          state_nxt = zero_r ? S_OUT : S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (t_take && t_end) begin
          state_nxt = end_room ? S_A_WR : S_OUT;
        end else if (t_take && t_fit) begin
          state_nxt = split_room ? S_A_WR : S_OUT;
        end else if (step_full) begin
          state_nxt = S_OUT;
        end
      end
      S_A_WR: begin
        if (cnt_r == last_r) begin
          state_nxt = S_OUT;
        end
      end
      S_F_HS:  state_nxt = S_F_FT;
      S_F_FT:  state_nxt = S_F_RDN;
      S_F_RDN: state_nxt = S_F_NT;
      S_F_NT:  state_nxt = (t_free && !t_end) ? S_F_MW0 : S_F_RDF;
      S_F_MW0: state_nxt = S_F_MW1;
      S_F_MW1: state_nxt = S_F_RDF;
      S_F_RDF: state_nxt = S_F_FW;
      S_F_FW:  state_nxt = S_F_PT;
      S_F_PT:  state_nxt = t_free ? S_F_HH : S_OUT;
      S_F_HH:  state_nxt = S_F_PF;
      S_F_PF:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory and adder control
  always_comb begin
    ready_nxt  = ready_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    zero_nxt   = zero_r;
    end_nxt    = end_r;
    wk_nxt     = wk_r;
    sw_nxt     = sw_r;
    cw_nxt     = cw_r;
    rem_nxt    = rem_r;
    hw_nxt     = hw_r;
    pw_nxt     = pw_r;
    hs_nxt     = hs_r;
    ps_nxt     = ps_r;
    result_nxt = result_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    case (state_r)
      S_IDLE: begin
        // latch request, round size up to 8 bytes (in tag words)
        alu_op    = ALU_SUB;
        alu_a     = AluW'(in_block_address[15:2]);
        alu_b     = AluW'(1);
        sw_nxt    = {(AddrW'(({1'b0, in_request_size} + 17'd7) >> 3)), 1'b0};
        zero_nxt  = (in_request_size == 16'd0);
        wk_nxt    = '0;
        first_nxt = 1'b1;
        cnt_nxt   = '0;
        result_nxt = '0;
        raddr     = '0;
        if (in_op) begin
          hw_nxt     = alu_y[AddrW-1:0];
          raddr      = alu_y[AddrW-1:0];
          status_nxt = (in_block_address == 16'd0) ? ST_NULL : ST_OK;
        end else begin
          status_nxt = (in_request_size == 16'd0) ? ST_ZERO : ST_OK;
        end
      end
      S_SETUP: begin
        // start chunk at word 0, free end chunk at word 2
        we        = 1'b1;
        waddr     = AddrW'(cnt_r);
        wdata     = (cnt_r < 2'd2) ? FlagStart : (FlagFree | FlagEnd);
        cnt_nxt   = cnt_r + 2'd1;
        ready_nxt = 1'b1;
        raddr     = '0;
      end
      S_A_CHK: begin
        // step to the next chunk header
        alu_a = AluW'(wk_r);
        alu_b = AluW'(t_cw) + AluW'(2);
        cnt_nxt = '0;
        result_nxt = {wk_r[AddrW-1:0], 2'b00} + 16'd4;
        cw_nxt  = t_cw;
        rem_nxt = {t_cw - sw_r[AddrW-1:0] - AddrW'(2), 2'b00};
        if (t_take && t_end) begin
          end_nxt  = 1'b1;
          last_nxt = 2'd3;
          if (!end_room) begin
            status_nxt = ST_FULL;
            result_nxt = '0;
          end
        end else if (t_take && t_fit) begin
          end_nxt  = 1'b0;
          last_nxt = ({1'b0, t_cw} == sw_r) ? 2'd1 : 2'd3;
          if (!split_room) begin
            status_nxt = ST_FULL;
            result_nxt = '0;
          end
        end else if (step_full) begin
          status_nxt = ST_FULL;
          result_nxt = '0;
        end else begin
          wk_nxt    = alu_y[15:0];
          raddr     = alu_y[AddrW-1:0];
          first_nxt = 1'b0;
        end
      end
      S_A_WR: begin
        // header/footer of the taken chunk, then end chunk or remainder
        we      = 1'b1;
        alu_a   = AluW'(wk_r);
        cnt_nxt = cnt_r + 2'd1;
        case (cnt_r)
          2'd0: begin
            alu_b = '0;
            wdata = {sw_r[AddrW-1:0], 2'b00};
          end
          2'd1: begin
            alu_b = AluW'(sw_r) + AluW'(1);
            wdata = {sw_r[AddrW-1:0], 2'b00};
          end
          2'd2: begin
            alu_b = AluW'(sw_r) + AluW'(2);
            wdata = end_r ? (FlagFree | FlagEnd) : (rem_r | FlagFree);
          end
          default: begin
            alu_b = end_r ? (AluW'(sw_r) + AluW'(3)) : (AluW'(cw_r) + AluW'(1));
            wdata = end_r ? (FlagFree | FlagEnd) : (rem_r | FlagFree);
          end
        endcase
        waddr = alu_y[AddrW-1:0];
      end
      S_F_HS: begin
        // mark chunk free
        hs_nxt = tag_bytes(rdata);
        we     = 1'b1;
        waddr  = hw_r;
        wdata  = tag_bytes(rdata) | FlagFree;
      end
      S_F_FT: begin
        alu_a = AluW'(hw_r);
        alu_b = AluW'(hs_r[15:2]) + AluW'(1);
        we    = 1'b1;
        waddr = alu_y[AddrW-1:0];
        wdata = hs_r | FlagFree;
      end
      S_F_RDN: begin
        alu_a = AluW'(hw_r);
        alu_b = AluW'(hs_r[15:2]) + AluW'(2);
        raddr = alu_y[AddrW-1:0];
      end
      S_F_NT: begin
        // merge with a free next chunk
        alu_a = AluW'(hs_r);
        alu_b = AluW'(tag_bytes(rdata)) + AluW'(8);
        if (t_free && !t_end) begin
          hs_nxt = alu_y[15:0];
        end
      end
      S_F_MW0: begin
        we    = 1'b1;
        waddr = hw_r;
        wdata = hs_r | FlagFree;
      end
      S_F_MW1: begin
        alu_a = AluW'(hw_r);
        alu_b = AluW'(hs_r[15:2]) + AluW'(1);
        we    = 1'b1;
        waddr = alu_y[AddrW-1:0];
        wdata = hs_r | FlagFree;
      end
      S_F_RDF: begin
        // previous chunk footer
        raddr = hw_r - AddrW'(1);
      end
      S_F_FW: begin
        alu_op = ALU_SUB;
        alu_a  = AluW'(hw_r);
        alu_b  = AluW'(t_cw) + AluW'(2);
        pw_nxt = alu_y[AddrW-1:0];
        raddr  = alu_y[AddrW-1:0];
      end
      S_F_PT: begin
        ps_nxt = tag_bytes(rdata);
        raddr  = hw_r;
      end
      S_F_HH: begin
        // merge into a free previous chunk
        alu_a  = AluW'(ps_r);
        alu_b  = AluW'(tag_bytes(rdata)) + AluW'(8);
        hs_nxt = alu_y[15:0];
        we     = 1'b1;
        waddr  = pw_r;
        wdata  = alu_y[15:0] | FlagFree;
      end
      S_F_PF: begin
        alu_a = AluW'(pw_r);
        alu_b = AluW'(hs_r[15:2]) + AluW'(1);
        we    = 1'b1;
        waddr = alu_y[AddrW-1:0];
        wdata = hs_r | FlagFree;
      end
      S_OUT: begin
        raddr = '0;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
    first_r  <= first_nxt;
    zero_r   <= zero_nxt;
    end_r    <= end_nxt;
    wk_r     <= wk_nxt;
    sw_r     <= sw_nxt;
    cw_r     <= cw_nxt;
    rem_r    <= rem_nxt;
    hw_r     <= hw_nxt;
    pw_r     <= pw_nxt;
    hs_r     <= hs_nxt;
    ps_r     <= ps_nxt;
    result_r <= result_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/bta_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bta_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int Width = 16,
  parameter int Depth = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/bta_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bta_alu: shared address adder
// Add or subtract unit shared by the address and size steps of the sequencer.
// ----------------------------------------------------------------------------
module bta_alu (
  input  wire bta_pkg::alu_op_t           op,
  input  wire logic [bta_pkg::AluW-1:0]   a,
  input  wire logic [bta_pkg::AluW-1:0]   b,
  output logic      [bta_pkg::AluW-1:0]   y
);
  import bta_pkg::*;

  // add or subtract
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: boundary tag heap allocator testbench
// Drives allocate and free requests through the valid/stall handshake, keeps
// its own copy of the tag heap to predict every result, and compares each
// returned address and status in order under random sender gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  import bta_pkg::*;

  localparam int TW = TagWords;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
  } heap_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [15:0] in_request_size;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_result_address;
  status_t     out_status;

  boundary_tag_heap_allocator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_request_size   (in_request_size),
    .in_block_address  (in_block_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_address(out_result_address),
    .out_status        (out_status)
  );

  // shadow heap
  int unsigned   shadow_tags[TW];
  bit            shadow_ready;
  heap_result_t  heap_results_q[$];
  int unsigned   live_blocks[$];
  int            mismatches;
  int            n_alloc_ok, n_full, n_zero, n_free, n_null, n_checked;
  bit            hold_req;
  int            hold_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", heap_results_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void chunk_write(int unsigned hw, int unsigned sz, int unsigned fl);
    int unsigned v;
    int unsigned h;
    v = (sz & ~32'd7) | fl;
    h = hw % TW;
    shadow_tags[h] = v;
    shadow_tags[(h + 1 + (sz & ~32'd7) / 4) % TW] = v;
  endfunction

  function automatic void shadow_setup();
    chunk_write(0, 0, FlagStart);
    chunk_write(2, 0, FlagFree | FlagEnd);
    shadow_ready = 1'b1;
  endfunction

  function automatic heap_result_t predict_alloc(int unsigned req);
    heap_result_t r;
    longint unsigned h, s, c;
    int unsigned t;
    if (!shadow_ready) shadow_setup();
    r.addr = '0;
    r.status = ST_FULL;
    if (req == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    s = (longint'(req) + 7) / 8 * 8;
    h = 0;
    forever begin
      h = h + 8 + (shadow_tags[(h / 4) % TW] & ~32'd7);
      if (h / 4 >= TW) break;
      t = shadow_tags[h / 4];
      if (!(t & FlagFree)) continue;
      if (t & FlagEnd) begin
        if (h / 4 + 4 + s / 4 > TW) break;
        chunk_write(32'(h / 4), 32'(s), 0);
        chunk_write(32'((h + 8 + s) / 4), 0, FlagFree | FlagEnd);
        r.addr = 16'((h + 4) & 16'hFFFF);
        r.status = ST_OK;
        return r;
      end
      c = t & ~32'd7;
      if (c == s || c >= s + 8) begin
        if (h / 4 + 1 + c / 4 >= TW) break;
        chunk_write(32'(h / 4), 32'(s), 0);
        if (c != s) chunk_write(32'((h + 8 + s) / 4), 32'(c - s - 8), FlagFree);
        r.addr = 16'((h + 4) & 16'hFFFF);
        r.status = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic heap_result_t predict_free(int unsigned addr);
    heap_result_t r;
    int unsigned hw, hs, nw, nt, fw, pw, pt;
    r.addr = '0;
    if (addr == 0) begin
      r.status = ST_NULL;
      return r;
    end
    r.status = ST_OK;
    if (!shadow_ready) return r;
    hw = ((addr >> 2) + TW - 1) % TW;
    hs = shadow_tags[hw] & ~32'd7;
    chunk_write(hw, hs, FlagFree);
    nw = (hw + 2 + hs / 4) % TW;
    nt = shadow_tags[nw];
    if ((nt & FlagFree) && !(nt & FlagEnd)) begin
      hs = hs + (nt & ~32'd7) + 8;
      chunk_write(hw, hs, FlagFree);
    end
    fw = (hw + TW - 1) % TW;
    pw = (fw + TW - ((shadow_tags[fw] & ~32'd7) / 4) % TW + TW - 1) % TW;
    pt = shadow_tags[pw];
    if (pt & FlagFree) begin
      hs = (pt & ~32'd7) + (shadow_tags[hw] & ~32'd7) + 8;
      chunk_write(pw, hs, FlagFree);
    end
    return r;
  endfunction

  // send one request; call right after a rising edge
  task automatic send_request(input logic op, input logic [15:0] size,
                              input logic [15:0] addr, output heap_result_t res);
    in_valid         <= 1'b1;
    in_op            <= op;
    in_request_size  <= size;
    in_block_address <= addr;
    do @(posedge clk); while (in_stall);
    res = op ? predict_free(addr) : predict_alloc(size);
    heap_results_q.push_back(res);
    if (op) begin
      if (res.status == ST_NULL) n_null++;
      else n_free++;
    end else begin
      case (res.status)
        ST_OK:   begin n_alloc_ok++; live_blocks.push_back(res.addr); end
        ST_ZERO: n_zero++;
        default: n_full++;
      endcase
    end
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic do_alloc(input logic [15:0] size);
    heap_result_t r;
    send_request(1'b0, size, 16'($urandom), r);
  endtask

  // free a live block chosen by position
  task automatic do_free_at(input int idx);
    heap_result_t r;
    int unsigned a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_request(1'b1, 16'($urandom), 16'(a), r);
  endtask

  task automatic free_all_random();
    while (live_blocks.size() > 0) begin
      do_free_at($urandom_range(live_blocks.size() - 1));
      idle_gap($urandom_range(0, 2));
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  // receiver stall pattern and long hold
  logic [7:0] rx_cnt;
  logic [1:0] rx_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cnt <= '0;
      rx_mode <= '0;
      hold_cycles <= 0;
    end else begin
      rx_cnt <= rx_cnt + 8'd1;
      if (rx_cnt == 0) rx_mode <= 2'($urandom);
      if (hold_req && hold_cycles == 0) hold_cycles <= 400;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      if (hold_cycles > 1) out_stall <= 1'b1;
      else case (rx_mode)
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(2) == 0);
        2'd2:    out_stall <= (rx_cnt[2:0] < 3'd5);
        default: out_stall <= rx_cnt[4];
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (heap_results_q.size() == 0) begin
        report_mismatch("unexpected result", out_result_address, 0);
      end else begin
        heap_result_t w;
        w = heap_results_q.pop_front();
        n_checked++;
        if (out_result_address !== w.addr)
          report_mismatch("result_address", out_result_address, w.addr);
        if (out_status !== w.status)
          report_mismatch("status", out_status, w.status);
      end
    end
  end

  // free and null requests before the heap exists, then two zero-size allocates
  task automatic test_before_setup();
    heap_result_t r;
    send_request(1'b1, 16'hFFFF, 16'hFFFF, r);
    send_request(1'b1, 16'h0000, 16'h0000, r);
    send_request(1'b1, 16'h1234, 16'h5554, r);
    send_request(1'b0, 16'h0000, 16'hFFFF, r);
    send_request(1'b0, 16'h0000, 16'h0000, r);
  endtask

  // rounding, exact fit, split, neighbour merges
  task automatic test_fit_and_merge();
    heap_result_t r;
    do_alloc(16'd1);
    do_alloc(16'd8);
    do_alloc(16'd9);
    do_alloc(16'd64);
    do_alloc(16'd24);
    do_free_at(1);              // 8-byte hole
    do_alloc(16'd7);            // exact fit
    do_free_at(2);              // 64-byte hole
    do_alloc(16'd16);           // split
    do_free_at(1);
    do_free_at(0);              // neighbours in use, no merge
    do_free_at(0);              // merge with free previous
    send_request(1'b1, 16'd0, 16'd0, r);
    free_all_random();
  endtask

  // grow to the end of the heap, then ask for more than fits
  task automatic test_grow_full();
    repeat (9) do_alloc(16'd8000);
    do_alloc(16'hFFFF);
    do_alloc(16'd65528);
    do_alloc(16'd1);
    free_all_random();
    do_alloc(16'hFFFF);
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (30) begin
      if (live_blocks.size() > 0 && $urandom_range(1)) do_free_at(0);
      else do_alloc(16'($urandom_range(1, 100)));
    end
    hold_req = 1'b0;
    free_all_random();
  endtask

  // mixed traffic in bursts
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int pick;
    heap_result_t r;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          send_request(1'b1, 16'($urandom), 16'd0, r);
        end else if (pick < 6) begin
          do_alloc(16'd0);
        end else if (pick < 8) begin
          do_alloc(16'($urandom));
        end else if (pick < 50 + 2 * (30 - live_blocks.size()) &&
                     live_blocks.size() < 60) begin
          if (pick < 12) do_alloc(16'($urandom_range(1, 4096)));
          else do_alloc(16'($urandom_range(1, 96)));
        end else if (live_blocks.size() > 0) begin
          do_free_at($urandom_range(live_blocks.size() - 1));
        end else begin
          do_alloc(16'($urandom_range(1, 96)));
        end
        sent++;
      end
      idle_gap($urandom_range(0, 6));
    end
    free_all_random();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_request_size = '0;
    in_block_address = '0;
    hold_req = 1'b0;
    mismatches = 0;
    n_alloc_ok = 0; n_full = 0; n_zero = 0; n_free = 0; n_null = 0; n_checked = 0;
    shadow_ready = 1'b0;
    foreach (shadow_tags[i]) shadow_tags[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_setup();
    test_fit_and_merge();
    test_grow_full();
    test_backpressure();
    test_random_traffic(1600);

    in_valid <= 1'b0;
    while (heap_results_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d allocations, %0d out-of-space, %0d zero-size", n_alloc_ok, n_full,
             n_zero);
    $display("covered %0d frees, %0d null frees; %0d results compared", n_free, n_null,
             n_checked);
    if (mismatches == 0 && heap_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
